>>> sv/det_pkg.sv
package det_pkg;

	// Samples per input byte, oldest in bit 7
	localparam int BYTE_SAMPLES = 8;
	// Width of the emitted timestamp
	localparam int EDGE_W = 32;
	// A byte splits into at most nine runs (eight transitions)
	localparam int RUNS = 9;
	// Run lengths stay at or below 8, run weights at or below 9
	localparam int RUN_W = 4;
	// Transition count, 0 to 8
	localparam int TR_W = 4;
	// Above any real weight, so the first inner run it meets always replaces it in the search
	localparam logic [RUN_W-1:0] NO_WEIGHT = '1;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_time;
		logic              edge_level;
		logic              last_of_byte;
	} edge_item_t;

	// Status of the run splitter and merger, seen by the sequencer
	typedef struct packed {
		logic             busy;
		logic [TR_W-1:0]  trans;
		logic [RUN_W-1:0] len0;
		logic [RUN_W-1:0] len1;
	} rm_stat_t;

endpackage

>>> sv/det_state_mem.sv
module det_state_mem import det_pkg::*; #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rd_en,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem [1];
	logic         valid_q;
	logic [W-1:0] rd_data_q;

	// An entry never written reads as the reset state (all zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[0] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q ? mem[0] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/det_run_merge.sv
module det_run_merge import det_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] sample_byte,
	input  logic       level,
	output rm_stat_t   stat
);

	logic [RUN_W-1:0] len_q [RUNS];
	logic [RUN_W-1:0] wts_q [RUNS];
	logic [TR_W-1:0]  trans_q;

	logic [RUN_W-1:0] split_len [RUNS];
	logic [RUN_W-1:0] split_wts [RUNS];
	logic [TR_W-1:0]  split_tr;
	logic [RUN_W-1:0] run_len;
	logic [RUN_W-1:0] run_wt;
	logic             lvl;
	logic             smp;

	logic [RUN_W-1:0] best;
	logic [TR_W-1:0]  pick;
	logic [RUN_W-1:0] mrg_len [RUNS];
	logic [RUN_W-1:0] mrg_wts [RUNS];
	logic             busy;

	// Split the byte into runs, starting from the level left by the previous byte
	always_comb begin
		lvl      = level;
		split_tr = '0;
		run_len  = '0;
		run_wt   = '0;
		smp      = 1'b0;
		for (int k = 0; k < RUNS; k++) begin
			split_len[k] = '0;
			split_wts[k] = '0;
		end
		for (int pos = 7; pos >= 0; pos--) begin
			smp = sample_byte[pos];
			if (smp == lvl) begin
				run_len = run_len + RUN_W'(1);
				run_wt  = run_wt + ((pos == 7) ? RUN_W'(2) : RUN_W'(1));
			end else begin
				split_len[split_tr] = run_len;
				split_wts[split_tr] = run_wt;
				split_tr = split_tr + TR_W'(1);
				run_len  = RUN_W'(1);
				run_wt   = RUN_W'(1);
			end
			lvl = smp;
		end
		split_len[split_tr] = run_len;
		split_wts[split_tr] = run_wt;
	end

	assign busy = (trans_q > TR_W'(2));

	// One merge step: lowest-weight inner run, earliest on a tie
	always_comb begin
		best = NO_WEIGHT;
		pick = TR_W'(1);
		for (int i = 1; i < RUNS - 1; i++) begin
			if ((TR_W'(i) < trans_q) && (wts_q[i] < best)) begin
				best = wts_q[i];
				pick = TR_W'(i);
			end
		end
		mrg_len = len_q;
		mrg_wts = wts_q;
		mrg_len[pick - TR_W'(1)] = len_q[pick - TR_W'(1)] + len_q[pick] + len_q[pick + TR_W'(1)];
		mrg_wts[pick - TR_W'(1)] = wts_q[pick - TR_W'(1)] + wts_q[pick] + wts_q[pick + TR_W'(1)];
		for (int j = 1; j < RUNS - 2; j++) begin
			if (TR_W'(j) >= pick) begin
				mrg_len[j] = len_q[j + 2];
				mrg_wts[j] = wts_q[j + 2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= '0;
		end else if (load) begin
			trans_q <= split_tr;
		end else if (busy) begin
			trans_q <= trans_q - TR_W'(2);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q <= split_len;
			wts_q <= split_wts;
		end else if (busy) begin
			len_q <= mrg_len;
			wts_q <= mrg_wts;
		end
	end

	assign stat.busy  = busy;
	assign stat.trans = trans_q;
	assign stat.len0  = len_q[0];
	assign stat.len1  = len_q[1];

endmodule

>>> sv/det_out_buf.sv
module det_out_buf import det_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_cnt,
	input  edge_item_t item0,
	input  edge_item_t item1,
	output logic       empty,
	output logic       out_valid,
	input  logic       out_ready,
	output edge_item_t out_item
);

	logic [1:0] cnt_q;
	edge_item_t slot0_q;
	edge_item_t slot1_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && out_ready;

	// Push only lands on an empty buffer, so it never meets a pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= item0;
			slot1_q <= item1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign empty     = (cnt_q == 2'd0);
	assign out_valid = !empty;
	assign out_item  = slot0_q;

endmodule

>>> sv/deglitching_edge_timestamper_top.sv
// An accepted byte passes through S_LOAD and S_MERGE before its edges enter the output buffer.
// Only one byte is in flight; a byte takes m = 0..3 merge steps; the run merger does one
//   merge per cycle and the state memory is read and written once per byte.
// A byte leaves at most two transitions; their items wait in a two-entry output buffer while the next byte is taken.
// Reset (arst_n low, asynchronous) clears the sequencer, the buffer and the state-memory
//   valid bit, so the line level and sample timer read as zero until first written.
module deglitching_edge_timestamper_top import det_pkg::*; #(
	parameter int TIMER_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        sample_byte,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [EDGE_W-1:0] edge_time,
	output logic              edge_level,
	output logic              last_of_byte
);

	// State word: {line level, sample timer}
	localparam int ST_W = TIMER_BITS + 1;
	// Timer bits that reach the 32-bit timestamp
	localparam int LO_W = (TIMER_BITS < EDGE_W) ? TIMER_BITS : EDGE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_MERGE
	} state_t;

	state_t state_q;

	logic [7:0]            byte_q;
	logic                  restart_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  level_q;

	logic                  in_xfer;
	logic [ST_W-1:0]       rd_data;
	logic [ST_W-1:0]       wr_data;
	logic                  wr_en;
	logic [TIMER_BITS-1:0] cur_timer;
	logic                  cur_level;

	rm_stat_t              rm_stat;

	logic                  buf_empty;
	logic                  buf_push;
	logic [1:0]            push_cnt;
	logic                  emit_done;
	logic [EDGE_W-1:0]     base_time;
	logic [RUN_W:0]        len_sum;
	edge_item_t            item0;
	edge_item_t            item1;
	edge_item_t            out_item;

	// Only one byte is in flight, so the state read of the next byte always
	// sees the write-back of this one: the sequencer is the interlock.
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// Apply restart on the word read back from the state memory
	assign cur_timer = restart_q ? '0 : rd_data[TIMER_BITS-1:0];
	assign cur_level = restart_q ? 1'b0 : rd_data[TIMER_BITS];

	// Write back the new level (newest sample) and the advanced timer; it wraps
	assign wr_en   = (state_q == S_LOAD);
	assign wr_data = {byte_q[0], cur_timer + TIMER_BITS'(BYTE_SAMPLES)};

	det_state_mem #(
		.W (ST_W)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	det_run_merge u_run_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (wr_en),
		.sample_byte (byte_q),
		.level       (cur_level),
		.stat        (rm_stat)
	);

	// Edge times: timer before the byte plus the offset of each kept edge
	assign base_time = EDGE_W'(timer_q[LO_W-1:0]);
	assign len_sum   = {1'b0, rm_stat.len0} + {1'b0, rm_stat.len1};

	assign item0.edge_time    = base_time + EDGE_W'(rm_stat.len0);
	assign item0.edge_level   = ~level_q;
	assign item0.last_of_byte = (rm_stat.trans == TR_W'(1));
	assign item1.edge_time    = base_time + EDGE_W'(len_sum);
	assign item1.edge_level   = level_q;
	assign item1.last_of_byte = 1'b1;

	// Once merging settles at most two transitions remain
	assign push_cnt  = (rm_stat.trans >= TR_W'(2)) ? 2'd2 : rm_stat.trans[1:0];
	assign emit_done = (state_q == S_MERGE) && !rm_stat.busy
		&& (buf_empty || (rm_stat.trans == '0));
	assign buf_push  = emit_done && (rm_stat.trans != '0);

	det_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (buf_push),
		.push_cnt  (push_cnt),
		.item0     (item0),
		.item1     (item1),
		.empty     (buf_empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign edge_time    = out_item.edge_time;
	assign edge_level   = out_item.edge_level;
	assign last_of_byte = out_item.last_of_byte;

	// Sequencer: take a byte, load state and split runs, merge, hand off edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (emit_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the byte for the split and the pre-byte state for the timestamps
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q    <= sample_byte;
			restart_q <= restart;
		end
		if (wr_en) begin
			timer_q <= cur_timer;
			level_q <= cur_level;
		end
	end

`ifndef SYNTHESIS
	a_push_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		buf_push |-> buf_empty)
		else $error("edge push into a non-empty output buffer");

	a_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> $past(in_xfer))
		else $error("state load without an accepted byte");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("second byte accepted while state write-back pending");

	a_trans_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rm_stat.trans <= TR_W'(8))
		else $error("transition count beyond one byte");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import det_pkg::*;

	localparam int TIMER_BITS = 32;
	// Stop the run after this many cycles with no transaction on either side
	localparam int STALL_LIMIT = 2000;
	// Length of the receiver hold-off in the backpressure test
	localparam int HOLD_CYCLES = 300;
	// Cycles to watch for stray edges once nothing is expected any more
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        sample_byte;
	logic              restart;
	logic              out_valid;
	logic              out_ready;
	logic [EDGE_W-1:0] edge_time;
	logic              edge_level;
	logic              last_of_byte;

	// Shadow state of the timestamper, advanced once per accepted byte
	logic                  line_level;
	logic [TIMER_BITS-1:0] sample_count;

	// Edges predicted but not yet seen on the output, oldest first
	edge_item_t expected_edges[$];

	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  no_idle;
	bit  hold_req;

	// State of the synthetic line used for most random bytes
	logic line_now;
	int   toggle_in;

	deglitching_edge_timestamper_top #(
		.TIMER_BITS(TIMER_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_byte (sample_byte),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.edge_time   (edge_time),
		.edge_level  (edge_level),
		.last_of_byte(last_of_byte)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Pick an idle gap: mostly none or short, now and then a long one
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Split the byte into runs, fold away the weakest inner runs until at most
	// two transitions are left, and queue the surviving edges.
	function automatic void predict_edges(input logic [7:0] b, input logic rs);
		logic [RUN_W-1:0]      lens [RUNS];
		logic [RUN_W-1:0]      wts  [RUNS];
		logic [RUN_W-1:0]      run_len;
		logic [RUN_W-1:0]      run_wt;
		logic [RUN_W-1:0]      best;
		logic [TIMER_BITS-1:0] t;
		logic                  lvl;
		logic                  smp;
		int                    trans;
		int                    p;
		edge_item_t            e;

		if (rs) begin
			sample_count = '0;
			line_level   = 1'b0;
		end
		lvl     = line_level;
		trans   = 0;
		run_len = '0;
		run_wt  = '0;
		for (int pos = 7; pos >= 0; pos--) begin
			smp = b[pos];
			if (smp == lvl) begin
				// A first run that continues the old level earns a bonus
				if (pos == 7)
					run_wt++;
				run_len++;
				run_wt++;
			end else begin
				lens[trans] = run_len;
				wts[trans]  = run_wt;
				trans++;
				run_len = RUN_W'(1);
				run_wt  = RUN_W'(1);
			end
			lvl = smp;
		end
		lens[trans] = run_len;
		wts[trans]  = run_wt;

		while (trans > 2) begin
			best = NO_WEIGHT;
			p    = 1;
			// Strict compare keeps the earliest run on a tie
			for (int i = 1; i < trans; i++) begin
				if (wts[i] < best) begin
					best = wts[i];
					p    = i;
				end
			end
			lens[p-1] = lens[p-1] + lens[p] + lens[p+1];
			wts[p-1]  = wts[p-1] + wts[p] + wts[p+1];
			for (int i = p; i + 2 <= trans; i++) begin
				lens[i] = lens[i+2];
				wts[i]  = wts[i+2];
			end
			trans -= 2;
		end

		t = sample_count;
		if (trans > 0) begin
			t = t + TIMER_BITS'(lens[0]);
			e.edge_time    = t[EDGE_W-1:0];
			e.edge_level   = ~line_level;
			e.last_of_byte = (trans == 1);
			expected_edges.push_back(e);
		end
		if (trans > 1) begin
			t = t + TIMER_BITS'(lens[1]);
			e.edge_time    = t[EDGE_W-1:0];
			e.edge_level   = line_level;
			e.last_of_byte = 1'b1;
			expected_edges.push_back(e);
		end

		sample_count = sample_count + TIMER_BITS'(BYTE_SAMPLES);
		line_level   = b[0];
	endfunction

	// Next eight samples of a slow square wave with rare one-sample glitches
	function automatic logic [7:0] line_byte();
		logic [7:0] b;
		for (int pos = 7; pos >= 0; pos--) begin
			if (toggle_in == 0) begin
				line_now  = ~line_now;
				toggle_in = $urandom_range(1, 20);
			end
			toggle_in--;
			b[pos] = line_now;
			if ($urandom_range(0, 15) == 0)
				b[pos] = ~b[pos];
		end
		return b;
	endfunction

	// Offer one byte, starting at a falling edge; return at the falling edge
	// after its transaction.
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		sample_byte <= b;
		restart     <= rs;
		do
			@(posedge clk);
		while (!in_ready);
		predict_edges(b, rs);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		logic [7:0] b;
		logic       rs;
		repeat (count) begin
			// Favor a realistic line; keep some raw noise bytes in the mix
			if ($urandom_range(0, 9) < 6)
				b = line_byte();
			else
				b = 8'($urandom_range(0, 255));
			rs = ($urandom_range(0, 49) == 0);
			send_byte(b, rs);
		end
	endtask

	// Quiet input, random gaps between bytes, every byte an extreme or a corner of the merge
	task automatic test_directed();
		logic [8:0] vec [22];
		vec = '{
			{8'h00, 1'b0},  // no transition at all
			{8'hFF, 1'b0},  // first sample breaks from the old level, empty first run
			{8'hFF, 1'b0},  // level held, only the timer moves
			{8'h00, 1'b0},  // single edge at offset zero going low
			{8'h01, 1'b0},  // edge on the newest sample
			{8'h80, 1'b1},  // restart, then a one-sample pulse at the front
			{8'h55, 1'b0},  // seven transitions, several merge passes
			{8'hAA, 1'b0},
			{8'h3C, 1'b1},  // clean pulse, one rise and one fall
			{8'h10, 1'b0},  // lone glitch
			{8'hEF, 1'b0},
			{8'h66, 1'b0},  // tie between inner runs
			{8'h99, 1'b0},
			{8'h5A, 1'b0},
			{8'hA5, 1'b1},
			{8'h0F, 1'b0},
			{8'hF0, 1'b0},
			{8'h7E, 1'b0},
			{8'h81, 1'b0},
			{8'h24, 1'b0},
			{8'hDB, 1'b1},
			{8'h00, 1'b1}
		};
		foreach (vec[i])
			send_byte(vec[i][8:1], vec[i][0]);
	endtask

	task automatic test_random_stream();
		send_random(900);
	endtask

	// Hold the receiver off while bytes keep coming, so the buffer fills and
	// the input stalls.
	task automatic test_backpressure();
		no_idle  = 1'b1;
		hold_req = 1'b1;
		send_random(40);
		no_idle  = 1'b0;
	endtask

	// Back-to-back traffic with both sides always willing
	task automatic test_burst();
		no_idle = 1'b1;
		send_random(100);
		no_idle = 1'b0;
	endtask

	// Receiver: random ready pattern, plus one long hold-off on request
	initial begin
		int g;
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			g = idle_gap();
			if (g != 0) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
	end

	// Compare each output transaction with the oldest predicted edge
	always @(posedge clk) begin
		edge_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_edges.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected edge time=%0d level=%0b last=%0b",
						$realtime, edge_time, edge_level, last_of_byte);
				mismatches++;
			end else begin
				want = expected_edges.pop_front();
				if (edge_time !== want.edge_time || edge_level !== want.edge_level ||
						last_of_byte !== want.last_of_byte) begin
					if (mismatches < MAX_REPORTS)
						$display({"%0t: edge mismatch: expected time=%0d level=%0b last=%0b,",
							" got time=%0d level=%0b last=%0b"}, $realtime,
							want.edge_time, want.edge_level, want.last_of_byte,
							edge_time, edge_level, last_of_byte);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_byte  = '0;
		restart      = 1'b0;
		line_level   = 1'b0;
		sample_count = '0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		line_now     = 1'b0;
		toggle_in    = 5;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_stream();
		test_backpressure();
		test_burst();

		// Drop valid, drain what is still owed, then watch for strays
		in_valid <= 1'b0;
		while (expected_edges.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
